FILE: design/rcdbus_pkg.sv
package rcdbus_pkg;

    localparam int FRAME_BYTES_DEF  = 18;
    localparam int BUFFER_BYTES_DEF = 36;
    localparam int STORE_DEPTH      = 16;
    localparam int STORE_IDX_W      = $clog2(STORE_DEPTH);

    localparam int CHAN_W   = 11;
    localparam int BAND_W   = 10;
    localparam int SW_W     = 2;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CHAN_W-1:0] CENTER_RST     = 11'd1024;
    localparam logic [BAND_W-1:0] BAND_RIGHT_RST = 10'd15;
    localparam logic [BAND_W-1:0] BAND_LEFT_RST  = 10'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_CENTER   = 2'd0,
        CFG_DEADBAND_RIGHT = 2'd1,
        CFG_DEADBAND_LEFT  = 2'd2
    } cfg_idx_t;

    typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        center;
        logic [BAND_W-1:0]        band_right;
        logic [BAND_W-1:0]        band_left;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]        chan0;
        logic [CHAN_W-1:0]        chan1;
        logic [CHAN_W-1:0]        chan2;
        logic [CHAN_W-1:0]        chan3;
        logic [SW_W-1:0]          switch_left;
        logic [SW_W-1:0]          switch_right;
        logic signed [WORD_W-1:0] mouse_x;
        logic signed [WORD_W-1:0] mouse_y;
        logic signed [WORD_W-1:0] mouse_z;
        logic [WORD_W-1:0]        mouse_buttons;
        logic [WORD_W-1:0]        key_mask;
    } result_t;

    // snap to center when |ch - center| < band
    function automatic logic [CHAN_W-1:0] deadband(
        input logic [CHAN_W-1:0] ch,
        input logic [CHAN_W-1:0] center,
        input logic [BAND_W-1:0] band
    );
        logic signed [CHAN_W:0] d;
        logic [CHAN_W-1:0]      mag;
        d   = $signed({1'b0, ch}) - $signed({1'b0, center});
        mag = d[CHAN_W] ? CHAN_W'(-d) : d[CHAN_W-1:0];
        return (mag < {1'b0, band}) ? center : ch;
    endfunction

endpackage

FILE: design/rc_dbus_frame_decoder.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    rx_byte, line_idle
// out      output     out_valid / out_stall  chan0..3, switches, mouse, key_mask
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a frame goes from its idle item
// through the input register and the result register to the outputs.
// in_stall rises only when an idle item ending a full frame waits on a held result.
// Reset clears the byte count and stage valids and loads the config defaults.
// cfg_ready is always high.
module rc_dbus_frame_decoder #(
    parameter int FRAME_BYTES  = rcdbus_pkg::FRAME_BYTES_DEF,
    parameter int BUFFER_BYTES = rcdbus_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [7:0]                              rx_byte,
    input  logic                                    line_idle,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [rcdbus_pkg::CHAN_W-1:0]           chan0,
    output logic [rcdbus_pkg::CHAN_W-1:0]           chan1,
    output logic [rcdbus_pkg::CHAN_W-1:0]           chan2,
    output logic [rcdbus_pkg::CHAN_W-1:0]           chan3,
    output logic [rcdbus_pkg::SW_W-1:0]             switch_left,
    output logic [rcdbus_pkg::SW_W-1:0]             switch_right,
    output logic signed [rcdbus_pkg::WORD_W-1:0]    mouse_x,
    output logic signed [rcdbus_pkg::WORD_W-1:0]    mouse_y,
    output logic signed [rcdbus_pkg::WORD_W-1:0]    mouse_z,
    output logic [rcdbus_pkg::WORD_W-1:0]           mouse_buttons,
    output logic [rcdbus_pkg::WORD_W-1:0]           key_mask,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rcdbus_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcdbus_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rcdbus_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    frame_t  frame;
    result_t res;
    logic    load;
    logic    busy;
    logic    out_free;
    logic    cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STICK_CENTER:   cfg_next.center     = cfg_data[CHAN_W-1:0];
                CFG_DEADBAND_RIGHT: cfg_next.band_right = cfg_data[BAND_W-1:0];
                CFG_DEADBAND_LEFT:  cfg_next.band_left  = cfg_data[BAND_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center     <= CENTER_RST;
            cfg_reg.band_right <= BAND_RIGHT_RST;
            cfg_reg.band_left  <= BAND_LEFT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcdbus_collect #(
        .FRAME_BYTES  (FRAME_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .line_idle (line_idle),
        .out_free  (out_free),
        .load      (load),
        .busy      (busy),
        .frame     (frame)
    );

    rcdbus_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .frame     (frame),
        .cfg       (cfg_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_free  (out_free),
        .res       (res)
    );

    assign chan0         = res.chan0;
    assign chan1         = res.chan1;
    assign chan2         = res.chan2;
    assign chan3         = res.chan3;
    assign switch_left   = res.switch_left;
    assign switch_right  = res.switch_right;
    assign mouse_x       = res.mouse_x;
    assign mouse_y       = res.mouse_y;
    assign mouse_z       = res.mouse_z;
    assign mouse_buttons = res.mouse_buttons;
    assign key_mask      = res.key_mask;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> busy)
        else $error("input stalled with empty stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(out_valid && out_stall))
        else $error("held result overwritten");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !load) |=> !out_valid)
        else $error("result delivered twice");

    a_center_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == CFG_STICK_CENTER) |=> cfg_reg.center == $past(cfg_data))
        else $error("center register not written");

endmodule

FILE: design/rcdbus_collect.sv
module rcdbus_collect #(
    parameter int FRAME_BYTES  = rcdbus_pkg::FRAME_BYTES_DEF,
    parameter int BUFFER_BYTES = rcdbus_pkg::BUFFER_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                line_idle,
    input  logic                out_free,
    output logic                load,
    output logic                busy,
    output rcdbus_pkg::frame_t  frame
);
    import rcdbus_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_idle_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       store_reg [STORE_DEPTH];
    logic             adv;
    logic             full_frame;
    logic             accept;

    assign full_frame = s1_idle_reg && (cnt_reg == CNT_W'(FRAME_BYTES));
    assign load       = s1_valid_reg && full_frame && out_free;
    assign adv        = s1_valid_reg && (!full_frame || out_free);
    assign in_stall   = s1_valid_reg && !adv;
    assign accept     = in_valid && !in_stall;
    assign busy       = s1_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (adv)
        begin
            if (s1_idle_reg)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg < CNT_W'(BUFFER_BYTES))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_idle_reg <= line_idle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && !s1_idle_reg && (cnt_reg < CNT_W'(STORE_DEPTH)))
        begin
            store_reg[cnt_reg[STORE_IDX_W-1:0]] <= s1_byte_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            frame[i] = store_reg[i];
        end
    end

endmodule

FILE: design/rcdbus_decode.sv
module rcdbus_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rcdbus_pkg::frame_t  frame,
    input  rcdbus_pkg::cfg_t    cfg,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                out_free,
    output rcdbus_pkg::result_t res
);
    import rcdbus_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;
    logic [CHAN_W-1:0] c0, c1, c2, c3;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        c0 = {frame[1][2:0], frame[0]};
        c1 = {frame[2][5:0], frame[1][7:3]};
        c2 = {frame[4][0], frame[3], frame[2][7:6]};
        c3 = {frame[5][3:0], frame[4][7:1]};

        res_next.chan0         = deadband(c0, cfg.center, cfg.band_right);
        res_next.chan1         = deadband(c1, cfg.center, cfg.band_right);
        res_next.chan2         = deadband(c2, cfg.center, cfg.band_left);
        res_next.chan3         = deadband(c3, cfg.center, cfg.band_left);
        res_next.switch_left   = frame[5][5:4];
        res_next.switch_right  = frame[5][7:6];
        res_next.mouse_x       = $signed({frame[7], frame[6]});
        res_next.mouse_y       = $signed({frame[9], frame[8]});
        res_next.mouse_z       = $signed({frame[11], frame[10]});
        res_next.mouse_buttons = {frame[13], frame[12]};
        res_next.key_mask      = {frame[15], frame[14]};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

endmodule
